FILE: hw/rtl/mvsm_pkg.sv
package mvsm_pkg;

   // voice table and sample memory sizes
   localparam int VOICES       = 8;
   localparam int VOICE_W      = 3;
   localparam int SAMPLE_WORDS = 4096;
   localparam int ADDR_W       = $clog2(SAMPLE_WORDS);

   // field widths
   localparam int CMD_W    = 3;
   localparam int LEN_W    = 13;
   localparam int POS_W    = LEN_W - 1;
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int KIND_W   = 2;

   // fixed point: gain is unsigned Q2.14
   localparam int GAIN_FRAC  = 14;
   localparam int PROD_W     = GAIN_W + 1 + SAMPLE_W;
   localparam int SCALED_W   = PROD_W - GAIN_FRAC;
   localparam int ACC_W      = SCALED_W + VOICE_W;
   localparam int UNITY_GAIN = 16384;
   localparam int MAX_LENGTH = 4096;
   localparam int SAT_MAX    = 32767;
   localparam int SAT_MIN    = -32768;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_VOLUME = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MIX    = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NO_VOICE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MIXED    = 2'd2;

   // one step for the shared multiply-accumulate unit
   typedef struct packed {
      logic                       clear;
      logic                       valid;
      logic                       active;
      logic [GAIN_W-1:0]          gain;
      logic signed [SAMPLE_W-1:0] sample;
   } mac_req_type;

endpackage

FILE: hw/rtl/mvsm_sample_ram.sv
module mvsm_sample_ram (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [mvsm_pkg::ADDR_W-1:0]         wr_addr,
   input  logic signed [mvsm_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [mvsm_pkg::ADDR_W-1:0]         rd_addr,
   output logic signed [mvsm_pkg::SAMPLE_W-1:0] rd_data
);

   logic signed [mvsm_pkg::SAMPLE_W-1:0] mem [mvsm_pkg::SAMPLE_WORDS];
   logic signed [mvsm_pkg::SAMPLE_W-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mvsm_mac.sv
module mvsm_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  mvsm_pkg::mac_req_type             mac_req,
   output logic signed [mvsm_pkg::ACC_W-1:0] acc_sum,
   output logic                              busy
);

   logic                                 prod_valid_ff;
   logic signed [mvsm_pkg::PROD_W-1:0]   prod_ff;
   logic signed [mvsm_pkg::PROD_W-1:0]   prod_in;
   logic signed [mvsm_pkg::SCALED_W-1:0] scaled;
   logic signed [mvsm_pkg::ACC_W-1:0]    acc_ff;
   logic signed [mvsm_pkg::ACC_W-1:0]    acc_in;

   // gain times sample, an idle voice contributes nothing
   always_comb begin
      prod_in = '0;
      if (mac_req.active) begin
         prod_in = $signed({1'b0, mac_req.gain}) * mac_req.sample;
      end
   end

   // drop the fraction bits, floor toward minus infinity
   assign scaled = prod_ff[mvsm_pkg::PROD_W-1:mvsm_pkg::GAIN_FRAC];

   // exact running sum
   always_comb begin
      acc_in = acc_ff;
      if (mac_req.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + mvsm_pkg::ACC_W'(scaled);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= mac_req.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc_sum = acc_ff;
   assign busy    = prod_valid_ff;

endmodule

FILE: hw/rtl/multi_voice_sample_mixer.sv
// Mono sample mixer for up to eight voices playing out of a 4096-word sample memory.
// Request channel (req_*): one command word per handshake: write a sample, start a
// voice, stop a voice, set a voice's gain, or mix one output sample.
// Response channel (rsp_*): start returns the allocated voice or "no free voice",
// a mix tick returns the saturated 16-bit sum; write, stop and gain return nothing.
// A command is taken in one cycle and executed in the next; only a start can wait
// there, for the response register, which then holds its response.
// A mix tick walks the voices one per cycle through the sample memory read port
// and a single multiply-accumulate unit, then waits for the last product to reach
// the sum and for the response register to be free before answering.
// req_ready is high only while no command is being worked on.
// The response is held in an output register, so the next command is taken
// while a response waits; a command that must answer waits until that register
// is free, so a stalled receiver stalls the block only then.
// Synchronous reset stops all voices and sets every gain to unity; the sample
// memory is not cleared and must be written before it is played.
module multi_voice_sample_mixer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mvsm_pkg::CMD_W-1:0]            req_command,
   input  logic [mvsm_pkg::VOICE_W-1:0]          req_voice_index,
   input  logic [mvsm_pkg::ADDR_W-1:0]           req_sample_address,
   input  logic [mvsm_pkg::LEN_W-1:0]            req_sound_length,
   input  logic                                  req_loop_enable,
   input  logic signed [mvsm_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic [mvsm_pkg::GAIN_W-1:0]           req_volume_gain,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mvsm_pkg::KIND_W-1:0]           rsp_result_kind,
   output logic [mvsm_pkg::VOICE_W-1:0]          rsp_allocated_voice,
   output logic signed [mvsm_pkg::SAMPLE_W-1:0]  rsp_mixed_sample
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_MIX   = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0] state_ff, state_in;

   // latched command word
   logic [mvsm_pkg::CMD_W-1:0]           cmd_ff, cmd_in;
   logic [mvsm_pkg::VOICE_W-1:0]         cmd_voice_ff, cmd_voice_in;
   logic [mvsm_pkg::ADDR_W-1:0]          cmd_addr_ff, cmd_addr_in;
   logic [mvsm_pkg::LEN_W-1:0]           cmd_len_ff, cmd_len_in;
   logic                                 cmd_loop_ff, cmd_loop_in;
   logic signed [mvsm_pkg::SAMPLE_W-1:0] cmd_value_ff, cmd_value_in;
   logic [mvsm_pkg::GAIN_W-1:0]          cmd_gain_ff, cmd_gain_in;

   // voice table
   logic [mvsm_pkg::VOICES-1:0] voice_active_ff, voice_active_in;
   logic [mvsm_pkg::ADDR_W-1:0] voice_start_ff [mvsm_pkg::VOICES];
   logic [mvsm_pkg::ADDR_W-1:0] voice_start_in [mvsm_pkg::VOICES];
   logic [mvsm_pkg::LEN_W-1:0]  voice_length_ff [mvsm_pkg::VOICES];
   logic [mvsm_pkg::LEN_W-1:0]  voice_length_in [mvsm_pkg::VOICES];
   logic [mvsm_pkg::VOICES-1:0] voice_loop_ff, voice_loop_in;
   logic [mvsm_pkg::POS_W-1:0]  voice_pos_ff [mvsm_pkg::VOICES];
   logic [mvsm_pkg::POS_W-1:0]  voice_pos_in [mvsm_pkg::VOICES];
   logic [mvsm_pkg::GAIN_W-1:0] voice_gain_ff [mvsm_pkg::VOICES];
   logic [mvsm_pkg::GAIN_W-1:0] voice_gain_in [mvsm_pkg::VOICES];

   // mix walk
   logic [mvsm_pkg::VOICE_W-1:0] voice_cnt_ff, voice_cnt_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic                         rd_active_ff, rd_active_in;
   logic [mvsm_pkg::GAIN_W-1:0]  rd_gain_ff, rd_gain_in;

   // response register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mvsm_pkg::KIND_W-1:0]          rsp_kind_ff, rsp_kind_in;
   logic [mvsm_pkg::VOICE_W-1:0]         rsp_voice_ff, rsp_voice_in;
   logic signed [mvsm_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                                 rsp_load;
   logic                                 slot_free;

   // sample memory and arithmetic unit
   logic                                 ram_we;
   logic [mvsm_pkg::ADDR_W-1:0]          ram_rd_addr;
   logic signed [mvsm_pkg::SAMPLE_W-1:0] ram_rd_data;
   mvsm_pkg::mac_req_type                mac_req;
   logic signed [mvsm_pkg::ACC_W-1:0]    acc_sum;
   logic                                 mac_busy;

   logic                                 free_found;
   logic [mvsm_pkg::VOICE_W-1:0]         free_idx;
   logic [mvsm_pkg::LEN_W-1:0]           len_clamped;
   logic [mvsm_pkg::ADDR_W:0]            addr_sum;
   logic [mvsm_pkg::LEN_W-1:0]           pos_next;
   logic signed [mvsm_pkg::SAMPLE_W-1:0] sat_sample;

   mvsm_sample_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cmd_addr_ff),
      .wr_data (cmd_value_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mvsm_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_req (mac_req),
      .acc_sum (acc_sum),
      .busy    (mac_busy)
   );

   // lowest free voice
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int v = mvsm_pkg::VOICES - 1; v >= 0; v--) begin
         if (!voice_active_ff[v]) begin
            free_found = 1'b1;
            free_idx   = mvsm_pkg::VOICE_W'(v);
         end
      end
   end

   // length zero means one sample, longer than memory means whole memory
   always_comb begin
      len_clamped = cmd_len_ff;
      if (cmd_len_ff == '0) begin
         len_clamped = mvsm_pkg::LEN_W'(1);
      end else if (cmd_len_ff > mvsm_pkg::LEN_W'(mvsm_pkg::MAX_LENGTH)) begin
         len_clamped = mvsm_pkg::LEN_W'(mvsm_pkg::MAX_LENGTH);
      end
   end

   // saturate the mixed sum to 16 bits
   always_comb begin
      if (acc_sum > mvsm_pkg::ACC_W'(mvsm_pkg::SAT_MAX)) begin
         sat_sample = mvsm_pkg::SAMPLE_W'(mvsm_pkg::SAT_MAX);
      end else if (acc_sum < mvsm_pkg::ACC_W'(mvsm_pkg::SAT_MIN)) begin
         sat_sample = mvsm_pkg::SAMPLE_W'(mvsm_pkg::SAT_MIN);
      end else begin
         sat_sample = acc_sum[mvsm_pkg::SAMPLE_W-1:0];
      end
   end

   // read address and next position of the voice being visited
   assign addr_sum    = {1'b0, voice_start_ff[voice_cnt_ff]}
                        + {1'b0, voice_pos_ff[voice_cnt_ff]};
   assign ram_rd_addr = addr_sum[mvsm_pkg::ADDR_W-1:0];
   assign pos_next    = {1'b0, voice_pos_ff[voice_cnt_ff]} + mvsm_pkg::LEN_W'(1);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // feed the multiply-accumulate unit from the read stage
   always_comb begin
      mac_req        = '0;
      mac_req.clear  = (state_ff == ST_EXEC) && (cmd_ff == mvsm_pkg::CMD_MIX);
      mac_req.valid  = rd_valid_ff;
      mac_req.active = rd_active_ff;
      mac_req.gain   = rd_gain_ff;
      mac_req.sample = ram_rd_data;
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      cmd_voice_in    = cmd_voice_ff;
      cmd_addr_in     = cmd_addr_ff;
      cmd_len_in      = cmd_len_ff;
      cmd_loop_in     = cmd_loop_ff;
      cmd_value_in    = cmd_value_ff;
      cmd_gain_in     = cmd_gain_ff;
      voice_active_in = voice_active_ff;
      voice_start_in  = voice_start_ff;
      voice_length_in = voice_length_ff;
      voice_loop_in   = voice_loop_ff;
      voice_pos_in    = voice_pos_ff;
      voice_gain_in   = voice_gain_ff;
      voice_cnt_in    = voice_cnt_ff;
      rd_valid_in     = 1'b0;
      rd_active_in    = rd_active_ff;
      rd_gain_in      = rd_gain_ff;
      rsp_load        = 1'b0;
      rsp_kind_in     = rsp_kind_ff;
      rsp_voice_in    = rsp_voice_ff;
      rsp_sample_in   = rsp_sample_ff;
      ram_we          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_command;
               cmd_voice_in = req_voice_index;
               cmd_addr_in  = req_sample_address;
               cmd_len_in   = req_sound_length;
               cmd_loop_in  = req_loop_enable;
               cmd_value_in = req_sample_value;
               cmd_gain_in  = req_volume_gain;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               mvsm_pkg::CMD_WRITE: begin
                  ram_we   = 1'b1;
                  state_in = ST_IDLE;
               end
               mvsm_pkg::CMD_START: begin
                  if (slot_free) begin
                     rsp_load      = 1'b1;
                     rsp_sample_in = '0;
                     if (free_found) begin
                        voice_active_in[free_idx] = 1'b1;
                        voice_start_in[free_idx]  = cmd_addr_ff;
                        voice_length_in[free_idx] = len_clamped;
                        voice_loop_in[free_idx]   = cmd_loop_ff;
                        voice_pos_in[free_idx]    = '0;
                        voice_gain_in[free_idx]   =
                           mvsm_pkg::GAIN_W'(mvsm_pkg::UNITY_GAIN);
                        rsp_kind_in  = mvsm_pkg::KIND_ALLOC;
                        rsp_voice_in = free_idx;
                     end else begin
                        rsp_kind_in  = mvsm_pkg::KIND_NO_VOICE;
                        rsp_voice_in = '0;
                     end
                     state_in = ST_IDLE;
                  end
               end
               mvsm_pkg::CMD_STOP: begin
                  if (int'(cmd_voice_ff) < mvsm_pkg::VOICES) begin
                     voice_active_in[cmd_voice_ff] = 1'b0;
                  end
                  state_in = ST_IDLE;
               end
               mvsm_pkg::CMD_VOLUME: begin
                  if (int'(cmd_voice_ff) < mvsm_pkg::VOICES) begin
                     voice_gain_in[cmd_voice_ff] = cmd_gain_ff;
                  end
                  state_in = ST_IDLE;
               end
               mvsm_pkg::CMD_MIX: begin
                  voice_cnt_in = '0;
                  state_in     = ST_MIX;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_MIX: begin
            // issue the read for this voice and step its position
            rd_valid_in  = 1'b1;
            rd_active_in = voice_active_ff[voice_cnt_ff];
            rd_gain_in   = voice_gain_ff[voice_cnt_ff];
            if (voice_active_ff[voice_cnt_ff]) begin
               if (pos_next >= voice_length_ff[voice_cnt_ff]) begin
                  voice_pos_in[voice_cnt_ff] = '0;
                  if (!voice_loop_ff[voice_cnt_ff]) begin
                     voice_active_in[voice_cnt_ff] = 1'b0;
                  end
               end else begin
                  voice_pos_in[voice_cnt_ff] = pos_next[mvsm_pkg::POS_W-1:0];
               end
            end
            if (voice_cnt_ff == mvsm_pkg::VOICE_W'(mvsm_pkg::VOICES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               voice_cnt_in = voice_cnt_ff + mvsm_pkg::VOICE_W'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the last product to land in the sum and a free response register
            if (!rd_valid_ff && !mac_busy && slot_free) begin
               rsp_load      = 1'b1;
               rsp_kind_in   = mvsm_pkg::KIND_MIXED;
               rsp_voice_in  = '0;
               rsp_sample_in = sat_sample;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         rd_valid_ff     <= 1'b0;
         voice_active_ff <= '0;
         voice_loop_ff   <= '0;
         voice_cnt_ff    <= '0;
         for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
            voice_start_ff[v]  <= '0;
            voice_length_ff[v] <= '0;
            voice_pos_ff[v]    <= '0;
            voice_gain_ff[v]   <= mvsm_pkg::GAIN_W'(mvsm_pkg::UNITY_GAIN);
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         rd_valid_ff     <= rd_valid_in;
         voice_active_ff <= voice_active_in;
         voice_loop_ff   <= voice_loop_in;
         voice_cnt_ff    <= voice_cnt_in;
         voice_start_ff  <= voice_start_in;
         voice_length_ff <= voice_length_in;
         voice_pos_ff    <= voice_pos_in;
         voice_gain_ff   <= voice_gain_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cmd_voice_ff  <= cmd_voice_in;
      cmd_addr_ff   <= cmd_addr_in;
      cmd_len_ff    <= cmd_len_in;
      cmd_loop_ff   <= cmd_loop_in;
      cmd_value_ff  <= cmd_value_in;
      cmd_gain_ff   <= cmd_gain_in;
      rd_active_ff  <= rd_active_in;
      rd_gain_ff    <= rd_gain_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_voice_ff  <= rsp_voice_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_allocated_voice = rsp_voice_ff;
   assign rsp_mixed_sample    = rsp_sample_ff;

   // no free voice is reported only when every voice is playing
   a_no_voice_all_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_kind_in == mvsm_pkg::KIND_NO_VOICE) |-> (&voice_active_ff))
      else $error("no free voice reported while a voice was free");

   // an allocated voice was free and is playing afterwards
   a_alloc_was_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_kind_in == mvsm_pkg::KIND_ALLOC)
      |-> (!voice_active_ff[rsp_voice_in] ##1 voice_active_ff[rsp_voice_ff]))
      else $error("allocated voice was already in use");

   // the mix result is only formed once the arithmetic pipeline is empty
   a_mix_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_kind_in == mvsm_pkg::KIND_MIXED) |-> (!rd_valid_ff && !mac_busy))
      else $error("mix word produced with products still in flight");

   // no new word taken while the voice walk is running
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX || state_ff == ST_DRAIN) |-> !req_ready)
      else $error("word accepted during a mix walk");

endmodule

FILE: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // spare command codes, the block must ignore them
   localparam logic [mvsm_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [mvsm_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam int RANDOM_WORDS   = 840;
   localparam int HOLDOFF_WORDS  = 40;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int PAUSE_WORDS    = 24;
   localparam int STEADY_WORDS   = 120;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int TAIL_CYCLES    = 24;

   typedef struct {
      logic [mvsm_pkg::CMD_W-1:0]           command;
      logic [mvsm_pkg::VOICE_W-1:0]         voice;
      logic [mvsm_pkg::ADDR_W-1:0]          addr;
      logic [mvsm_pkg::LEN_W-1:0]           len;
      logic                                 loop_en;
      logic signed [mvsm_pkg::SAMPLE_W-1:0] value;
      logic [mvsm_pkg::GAIN_W-1:0]          gain;
   } mixer_word_type;

   typedef struct {
      logic [mvsm_pkg::KIND_W-1:0]          kind;
      logic [mvsm_pkg::VOICE_W-1:0]         voice;
      logic signed [mvsm_pkg::SAMPLE_W-1:0] level;
   } mixer_result_type;

   logic                                 clock;
   logic                                 reset               = 1'b1;
   logic                                 req_valid           = 1'b0;
   logic                                 req_ready;
   logic [mvsm_pkg::CMD_W-1:0]           req_command         = mvsm_pkg::CMD_WRITE;
   logic [mvsm_pkg::VOICE_W-1:0]         req_voice_index     = '0;
   logic [mvsm_pkg::ADDR_W-1:0]          req_sample_address  = '0;
   logic [mvsm_pkg::LEN_W-1:0]           req_sound_length    = '0;
   logic                                 req_loop_enable     = 1'b0;
   logic signed [mvsm_pkg::SAMPLE_W-1:0] req_sample_value    = '0;
   logic [mvsm_pkg::GAIN_W-1:0]          req_volume_gain     = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready           = 1'b1;
   logic [mvsm_pkg::KIND_W-1:0]          rsp_result_kind;
   logic [mvsm_pkg::VOICE_W-1:0]         rsp_allocated_voice;
   logic signed [mvsm_pkg::SAMPLE_W-1:0] rsp_mixed_sample;

   // mixer image: sample memory and voice table as the block should hold them
   logic signed [mvsm_pkg::SAMPLE_W-1:0] sample_image   [mvsm_pkg::SAMPLE_WORDS];
   bit                                   sample_written [mvsm_pkg::SAMPLE_WORDS];
   bit                                   voice_on       [mvsm_pkg::VOICES];
   bit [mvsm_pkg::ADDR_W-1:0]            voice_base     [mvsm_pkg::VOICES];
   bit [mvsm_pkg::LEN_W-1:0]             voice_len      [mvsm_pkg::VOICES];
   bit                                   voice_repeat   [mvsm_pkg::VOICES];
   bit [mvsm_pkg::ADDR_W-1:0]            voice_pos      [mvsm_pkg::VOICES];
   bit [mvsm_pkg::GAIN_W-1:0]            voice_gain     [mvsm_pkg::VOICES];
   mixer_result_type                     expected_results [$];

   int fail_count     = 0;
   int words_sent     = 0;
   int results_seen   = 0;
   int alloc_count    = 0;
   int no_voice_count = 0;
   int mix_count      = 0;
   int clip_count     = 0;
   bit idle_on        = 1'b1;
   bit hold_off_req   = 1'b0;

   multi_voice_sample_mixer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_voice_index     (req_voice_index),
      .req_sample_address  (req_sample_address),
      .req_sound_length    (req_sound_length),
      .req_loop_enable     (req_loop_enable),
      .req_sample_value    (req_sample_value),
      .req_volume_gain     (req_volume_gain),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_allocated_voice (rsp_allocated_voice),
      .rsp_mixed_sample    (rsp_mixed_sample)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one accepted word applied to the mixer image, answer queued if any
   function automatic void mix_model_step(input mixer_word_type w);
      mixer_result_type            r;
      longint                      acc;
      longint                      prod;
      logic [mvsm_pkg::ADDR_W-1:0] a;
      int                          slot;
      r.kind  = mvsm_pkg::KIND_MIXED;
      r.voice = '0;
      r.level = '0;
      acc     = 0;
      slot    = -1;
      case (w.command)
         mvsm_pkg::CMD_WRITE: begin
            sample_image[w.addr]   = w.value;
            sample_written[w.addr] = 1'b1;
         end
         mvsm_pkg::CMD_START: begin
            // lowest free voice wins
            for (int v = mvsm_pkg::VOICES - 1; v >= 0; v--)
               if (!voice_on[v]) slot = v;
            if (slot < 0) begin
               r.kind = mvsm_pkg::KIND_NO_VOICE;
               no_voice_count++;
            end else begin
               voice_on[slot]     = 1'b1;
               voice_base[slot]   = w.addr;
               voice_repeat[slot] = w.loop_en;
               voice_pos[slot]    = '0;
               voice_gain[slot]   = mvsm_pkg::GAIN_W'(mvsm_pkg::UNITY_GAIN);
               if (w.len == 0)
                  voice_len[slot] = mvsm_pkg::LEN_W'(1);
               else if (w.len > mvsm_pkg::MAX_LENGTH)
                  voice_len[slot] = mvsm_pkg::LEN_W'(mvsm_pkg::MAX_LENGTH);
               else
                  voice_len[slot] = w.len;
               r.kind  = mvsm_pkg::KIND_ALLOC;
               r.voice = mvsm_pkg::VOICE_W'(slot);
               alloc_count++;
            end
            expected_results.push_back(r);
         end
         mvsm_pkg::CMD_STOP: begin
            if (w.voice < mvsm_pkg::VOICES) voice_on[w.voice] = 1'b0;
         end
         mvsm_pkg::CMD_VOLUME: begin
            if (w.voice < mvsm_pkg::VOICES) voice_gain[w.voice] = w.gain;
         end
         mvsm_pkg::CMD_MIX: begin
            // gain times sample, floored, summed exactly, then clipped
            for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
               if (voice_on[v]) begin
                  a    = voice_base[v] + voice_pos[v];
                  prod = longint'(voice_gain[v]) * longint'(sample_image[a]);
                  acc += prod >>> mvsm_pkg::GAIN_FRAC;
                  if (int'(voice_pos[v]) + 1 >= int'(voice_len[v])) begin
                     voice_pos[v] = '0;
                     if (!voice_repeat[v]) voice_on[v] = 1'b0;
                  end else begin
                     voice_pos[v] = voice_pos[v] + 1'b1;
                  end
               end
            end
            if (acc > mvsm_pkg::SAT_MAX || acc < mvsm_pkg::SAT_MIN) clip_count++;
            if (acc > mvsm_pkg::SAT_MAX) acc = longint'(mvsm_pkg::SAT_MAX);
            if (acc < mvsm_pkg::SAT_MIN) acc = longint'(mvsm_pkg::SAT_MIN);
            r.level = mvsm_pkg::SAMPLE_W'(acc);
            mix_count++;
            expected_results.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic mixer_word_type random_word();
      mixer_word_type w;
      int             pick;
      w.voice   = mvsm_pkg::VOICE_W'($urandom);
      w.addr    = mvsm_pkg::ADDR_W'($urandom);
      w.len     = mvsm_pkg::LEN_W'($urandom);
      w.loop_en = 1'($urandom);
      w.value   = mvsm_pkg::SAMPLE_W'($urandom);
      w.gain    = mvsm_pkg::GAIN_W'($urandom);
      // enough starts and mixes that voices keep coming and going
      pick = $urandom_range(0, 99);
      if (pick < 24)      w.command = mvsm_pkg::CMD_WRITE;
      else if (pick < 44) w.command = mvsm_pkg::CMD_START;
      else if (pick < 53) w.command = mvsm_pkg::CMD_STOP;
      else if (pick < 65) w.command = mvsm_pkg::CMD_VOLUME;
      else if (pick < 98) w.command = mvsm_pkg::CMD_MIX;
      else w.command = mvsm_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      // sounds mostly sit low in memory or straddle the top
      pick = $urandom_range(0, 99);
      if (pick < 50)
         w.addr = mvsm_pkg::ADDR_W'($urandom_range(0, 127));
      else if (pick < 65)
         w.addr = mvsm_pkg::ADDR_W'($urandom_range(mvsm_pkg::SAMPLE_WORDS - 64,
                                                   mvsm_pkg::SAMPLE_WORDS - 1));
      // short sounds, with zero, maximum and oversized lengths now and then
      pick = $urandom_range(0, 99);
      if (pick < 70)      w.len = mvsm_pkg::LEN_W'($urandom_range(1, 32));
      else if (pick < 73) w.len = '0;
      else if (pick < 78) w.len = mvsm_pkg::LEN_W'(mvsm_pkg::MAX_LENGTH);
      else if (pick < 81)
         w.len = mvsm_pkg::LEN_W'($urandom_range(mvsm_pkg::MAX_LENGTH + 1,
                                                 (1 << mvsm_pkg::LEN_W) - 1));
      else                w.len = mvsm_pkg::LEN_W'($urandom_range(33, 512));
      // full-scale samples often, so the sum hits the rails
      if ($urandom_range(0, 3) == 0)
         w.value = $urandom_range(0, 1) ? mvsm_pkg::SAMPLE_W'(mvsm_pkg::SAT_MAX)
                                        : mvsm_pkg::SAMPLE_W'(mvsm_pkg::SAT_MIN);
      pick = $urandom_range(0, 99);
      if (pick < 20)      w.gain = mvsm_pkg::GAIN_W'(mvsm_pkg::UNITY_GAIN);
      else if (pick < 30) w.gain = '0;
      else if (pick < 40) w.gain = '1;
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // present one word and hold it until the block takes it
   task automatic drive_word(input mixer_word_type w);
      req_valid          <= 1'b1;
      req_command        <= w.command;
      req_voice_index    <= w.voice;
      req_sample_address <= w.addr;
      req_sound_length   <= w.len;
      req_loop_enable    <= w.loop_en;
      req_sample_value   <= w.value;
      req_volume_gain    <= w.gain;
      do begin
         @(posedge clock);
      end while (req_ready !== 1'b1);
      mix_model_step(w);
      words_sent++;
   endtask

   task automatic send_word(input mixer_word_type w);
      mixer_word_type              fill;
      logic [mvsm_pkg::ADDR_W-1:0] a;
      // random gap on the request side
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      // a mix must never read a sample word that was never written
      if (w.command == mvsm_pkg::CMD_MIX) begin
         for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
            a = voice_base[v] + voice_pos[v];
            if (voice_on[v] && !sample_written[a]) begin
               fill         = random_word();
               fill.command = mvsm_pkg::CMD_WRITE;
               fill.addr    = a;
               drive_word(fill);
            end
         end
      end
      drive_word(w);
   endtask

   task automatic send_fields(input logic [mvsm_pkg::CMD_W-1:0] cmd, input int voice,
                              input int addr, input int len, input bit loop_en,
                              input int value, input int gain);
      mixer_word_type w;
      w.command = cmd;
      w.voice   = mvsm_pkg::VOICE_W'(voice);
      w.addr    = mvsm_pkg::ADDR_W'(addr);
      w.len     = mvsm_pkg::LEN_W'(len);
      w.loop_en = loop_en;
      w.value   = mvsm_pkg::SAMPLE_W'(value);
      w.gain    = mvsm_pkg::GAIN_W'(gain);
      send_word(w);
   endtask

   task automatic send_random_words(input int count);
      mixer_word_type w;
      int             n;
      n = 0;
      while (n < count) begin
         w = random_word();
         send_word(w);
         // ignored codes do not count
         if (w.command <= mvsm_pkg::CMD_MIX) n++;
      end
   endtask

   task automatic wait_results_drained();
      int n;
      n = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         n++;
      end while (expected_results.size() != 0 && n < DRAIN_LIMIT);
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
   endtask

   task automatic test_directed_cases();
      // full-scale samples and the top word of memory
      send_fields(mvsm_pkg::CMD_WRITE, 0, 0, 1, 1'b0, mvsm_pkg::SAT_MAX,
                  mvsm_pkg::UNITY_GAIN);
      send_fields(mvsm_pkg::CMD_WRITE, 0, 1, 1, 1'b0, mvsm_pkg::SAT_MIN,
                  mvsm_pkg::UNITY_GAIN);
      send_fields(mvsm_pkg::CMD_WRITE, 0, mvsm_pkg::SAMPLE_WORDS - 1, 1, 1'b0, -1,
                  mvsm_pkg::UNITY_GAIN);
      // looping voice across the address wrap, one-shot voice of zero length
      send_fields(mvsm_pkg::CMD_START, 0, mvsm_pkg::SAMPLE_WORDS - 1, 3, 1'b1, 0, 0);
      send_fields(mvsm_pkg::CMD_START, 0, 0, 0, 1'b0, 0, 0);
      // maximum gain pushes the sum against both rails
      send_fields(mvsm_pkg::CMD_VOLUME, 0, 0, 1, 1'b0, 0, (1 << mvsm_pkg::GAIN_W) - 1);
      repeat (3) send_fields(mvsm_pkg::CMD_MIX, 0, 0, 1, 1'b0, 0, 0);
      send_fields(mvsm_pkg::CMD_VOLUME, 0, 0, 1, 1'b0, 0, 0);
      send_fields(mvsm_pkg::CMD_MIX, 0, 0, 1, 1'b0, 0, 0);
      // stop a playing voice, stop an idle one, gain on an idle one
      send_fields(mvsm_pkg::CMD_STOP, 0, 0, 1, 1'b0, 0, 0);
      send_fields(mvsm_pkg::CMD_STOP, 5, 0, 1, 1'b0, 0, 0);
      send_fields(mvsm_pkg::CMD_VOLUME, mvsm_pkg::VOICES - 1, 0, 1, 1'b0, 0, 1);
      // oversized and maximum length, then run out of voices
      send_fields(mvsm_pkg::CMD_START, 0, mvsm_pkg::SAMPLE_WORDS - 6,
                  (1 << mvsm_pkg::LEN_W) - 1, 1'b0, 0, 0);
      send_fields(mvsm_pkg::CMD_START, 0, 64, mvsm_pkg::MAX_LENGTH, 1'b1, 0, 0);
      repeat (mvsm_pkg::VOICES - 1) send_fields(mvsm_pkg::CMD_START, 0, 0, 2, 1'b1, 0, 0);
      send_fields(mvsm_pkg::CMD_MIX, 0, 0, 1, 1'b0, 0, 0);
      // spare command codes
      for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
         send_fields(mvsm_pkg::CMD_W'(c), 0, 0, 1, 1'b0, 0, 0);
   endtask

   task automatic test_random_traffic();
      send_random_words(RANDOM_WORDS);
   endtask

   // receiver holds off for a long stretch while answering words keep coming
   task automatic test_response_holdoff();
      mixer_word_type w;
      hold_off_req = 1'b1;
      repeat (HOLDOFF_WORDS) begin
         w         = random_word();
         w.command = $urandom_range(0, 3) == 0 ? mvsm_pkg::CMD_START : mvsm_pkg::CMD_MIX;
         send_word(w);
      end
      wait_results_drained();
   endtask

   // sender goes quiet until every answer is back, then carries on
   task automatic test_sender_pause();
      send_random_words(PAUSE_WORDS);
      wait_results_drained();
      send_random_words(PAUSE_WORDS);
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      send_random_words(STEADY_WORDS);
   endtask

   // response side ready, with random and long hold-offs
   initial begin : rsp_sink
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // each accepted response against the oldest outstanding answer
   initial begin : rsp_check
      mixer_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response kind %0d with nothing outstanding",
                                         rsp_result_kind));
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch($sformatf("result_kind %0d, wanted %0d",
                                            rsp_result_kind, want.kind));
               if (rsp_allocated_voice !== want.voice)
                  report_mismatch($sformatf("allocated_voice %0d, wanted %0d",
                                            rsp_allocated_voice, want.voice));
               if (rsp_mixed_sample !== want.level)
                  report_mismatch($sformatf("mixed_sample %0d, wanted %0d",
                                            rsp_mixed_sample, want.level));
            end
            results_seen++;
         end
      end
   end

   initial begin : watchdog
      #4ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      for (int v = 0; v < mvsm_pkg::VOICES; v++)
         voice_gain[v] = mvsm_pkg::GAIN_W'(mvsm_pkg::UNITY_GAIN);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic();
      test_response_holdoff();
      test_sender_pause();
      test_steady_stream();
      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d command words and %0d responses, with a long response hold-off",
               words_sent, results_seen);
      $display("and a drained pause: %0d allocations, %0d pool-full, %0d mixes, %0d clipped",
               alloc_count, no_voice_count, mix_count, clip_count);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/mvsm_pkg.sv
hw/rtl/mvsm_sample_ram.sv
hw/rtl/mvsm_mac.sv
hw/rtl/multi_voice_sample_mixer.sv
bench/tb.sv
